// ===== rtl/chmc_pkg.sv =====
// Shared constants, types and state encoding of the convex hull block.
`timescale 1ns / 1ps
package chmc_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int COORD_BITS  = 16;
  localparam int STACK_DEPTH = MAX_POINTS + 1;
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int SADDR_W     = $clog2(MAX_POINTS);
  localparam int HADDR_W     = $clog2(STACK_DEPTH);
  localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int PT_W        = 2 * COORD_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_KEY, S_ENDPT, S_HINIT, S_HFETCH, S_HCAP,
    S_HCHK, S_HRA, S_HRB, S_HMUL, S_HPROD, S_HCMP, S_HPUSH, S_EINIT, S_ERD,
    S_ELD, S_EMPTY, S_EWAIT, S_CLR
  } state_t;

  typedef struct packed {
    logic accept;
    logic ins_rd;
    logic ins_cmp;
    logic ins_key;
    logic hinit;
    logic hfetch;
    logic hcap;
    logic hra;
    logic hrb;
    logic hmul;
    logic hprod;
    logic hcmp;
    logic push;
    logic einit;
    logic erd;
    logic eld;
    logic eempty;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic j_zero;
    logic key_less;
    logic last;
    logic cnt_ge3;
    logic can_test;
    logic turn_bad;
    logic upper_end;
    logic hull_small;
    logic out_taken;
    logic out_last;
  } status_t;

endpackage

// ===== rtl/chmc_if.sv =====
// Valid/ready channel interfaces for input points and hull vertices.
`timescale 1ns / 1ps
interface chmc_point_if;
  import chmc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;
  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface chmc_hull_if;
  import chmc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] hull_x;
  logic signed [COORD_BITS-1:0] hull_y;
  logic                         hull_last;
  logic                         hull_empty;
  logic                         points_dropped;
  modport source (output valid, hull_x, hull_y, hull_last, hull_empty, points_dropped,
                  input ready);
  modport sink (input valid, hull_x, hull_y, hull_last, hull_empty, points_dropped,
                output ready);
endinterface

// ===== rtl/chmc_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module chmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/chmc_dp.sv =====
// Datapath: point store, hull stack, counters, cross product and output register.
`timescale 1ns / 1ps
module chmc_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  chmc_pkg::cmd_t                 cmd,
  output chmc_pkg::status_t              status,
  input  logic signed [chmc_pkg::COORD_BITS-1:0] in_x,
  input  logic signed [chmc_pkg::COORD_BITS-1:0] in_y,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [chmc_pkg::COORD_BITS-1:0] out_x,
  output logic signed [chmc_pkg::COORD_BITS-1:0] out_y,
  output logic                           out_last,
  output logic                           out_empty,
  output logic                           out_dropped
);
  import chmc_pkg::*;

  logic [CNT_W-1:0]          count;
  logic                      ovf;
  logic                      last;
  logic [SADDR_W-1:0]        j;
  logic [SADDR_W-1:0]        i;
  logic                      upper;
  logic [TOP_W-1:0]          top;
  logic [TOP_W-1:0]          lower_top;
  logic [HADDR_W-1:0]        k;
  point_t                    key;
  point_t                    p;
  point_t                    t1;
  point_t                    t2;
  logic signed [PROD_W-1:0]  prod1;
  logic signed [PROD_W-1:0]  prod2;

  logic                      st_we;
  logic [SADDR_W-1:0]        st_waddr;
  point_t                    st_wdata;
  logic [SADDR_W-1:0]        st_raddr;
  point_t                    st_rdata;
  logic                      hs_we;
  logic [HADDR_W-1:0]        hs_raddr;
  point_t                    hs_rdata;

  logic                      key_less;
  logic [CNT_W-1:0]          cnt_m1;
  logic [TOP_W-1:0]          top_m1;
  logic [TOP_W-1:0]          top_m2;
  logic [TOP_W-1:0]          top_p1;
  logic signed [DIFF_W-1:0]  dx1;
  logic signed [DIFF_W-1:0]  dy1;
  logic signed [DIFF_W-1:0]  dx2;
  logic signed [DIFF_W-1:0]  dy2;

  assign cnt_m1 = count - CNT_W'(1);
  assign top_m1 = top - TOP_W'(1);
  assign top_m2 = top - TOP_W'(2);
  assign top_p1 = top + TOP_W'(1);

  assign key_less = (key.x < st_rdata.x) || ((key.x == st_rdata.x) && (key.y < st_rdata.y));

  assign dx1 = DIFF_W'(t1.x) - DIFF_W'(t2.x);
  assign dy1 = DIFF_W'(t1.y) - DIFF_W'(t2.y);
  assign dx2 = DIFF_W'(p.x) - DIFF_W'(t2.x);
  assign dy2 = DIFF_W'(p.y) - DIFF_W'(t2.y);

  // Store port: shift during insertion, then the key at its slot.
  always_comb begin
    st_we    = (cmd.ins_cmp && key_less) || cmd.ins_key;
    st_waddr = j;
    st_wdata = cmd.ins_key ? key : st_rdata;
    if (cmd.ins_rd) begin
      st_raddr = j - SADDR_W'(1);
    end else if (upper) begin
      st_raddr = i - SADDR_W'(1);
    end else begin
      st_raddr = i;
    end
  end

  always_comb begin
    hs_we = cmd.push && (top < TOP_W'(STACK_DEPTH));
    if (cmd.hra) begin
      hs_raddr = top_m1[HADDR_W-1:0];
    end else if (cmd.hrb) begin
      hs_raddr = top_m2[HADDR_W-1:0];
    end else begin
      hs_raddr = k;
    end
  end

  chmc_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  chmc_ram #(.WIDTH(PT_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (hs_we),
    .waddr (top[HADDR_W-1:0]),
    .wdata (p),
    .raddr (hs_raddr),
    .rdata (hs_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      upper     <= 1'b0;
      top       <= '0;
    end else begin
      if (cmd.accept && (count == CNT_W'(MAX_POINTS))) begin
        ovf <= 1'b1;
      end
      if (cmd.ins_key) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.hinit) begin
        top   <= '0;
        upper <= 1'b0;
      end
      if (cmd.hcmp && (prod1 <= prod2)) begin
        top <= top_m1;
      end
      if (cmd.push) begin
        if (hs_we) begin
          top <= top_p1;
        end
        if (!upper && (i == cnt_m1[SADDR_W-1:0])) begin
          upper <= 1'b1;
        end
      end
      if (cmd.eld || cmd.eempty) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear) begin
        count <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key  <= '{x: in_x, y: in_y};
      last <= in_last;
      j    <= count[SADDR_W-1:0];
    end
    if (cmd.ins_cmp && key_less) begin
      j <= j - SADDR_W'(1);
    end
    if (cmd.hinit) begin
      i <= '0;
    end
    if (cmd.hcap) begin
      p <= st_rdata;
    end
    if (cmd.hrb) begin
      t1 <= hs_rdata;
    end
    if (cmd.hmul) begin
      t2 <= hs_rdata;
    end
    if (cmd.hprod) begin
      prod1 <= dx1 * dy2;
      prod2 <= dy1 * dx2;
    end
    if (cmd.push) begin
      if (!upper && (i == cnt_m1[SADDR_W-1:0])) begin
        lower_top <= hs_we ? top_p1 : top;
      end else begin
        i <= upper ? i - SADDR_W'(1) : i + SADDR_W'(1);
      end
    end
    if (cmd.einit) begin
      k <= '0;
    end
    if (out_valid && out_ready) begin
      k <= k + HADDR_W'(1);
    end
    if (cmd.eld) begin
      out_x     <= hs_rdata.x;
      out_y     <= hs_rdata.y;
      out_last  <= (k == top_m2[HADDR_W-1:0]);
      out_empty <= 1'b0;
      out_dropped <= ovf;
    end
    if (cmd.eempty) begin
      out_x       <= '0;
      out_y       <= '0;
      out_last    <= 1'b1;
      out_empty   <= 1'b1;
      out_dropped <= ovf;
    end
  end

  always_comb begin
    status.full       = (count == CNT_W'(MAX_POINTS));
    status.j_zero     = (j == '0);
    status.key_less   = key_less;
    status.last       = last;
    status.cnt_ge3    = (count >= CNT_W'(3));
    status.can_test   = (top >= TOP_W'(2)) && (!upper || (top > lower_top));
    status.turn_bad   = (prod1 <= prod2);
    status.upper_end  = upper && (i == SADDR_W'(1));
    status.hull_small = (top < TOP_W'(4));
    status.out_taken  = out_valid && out_ready;
    status.out_last   = out_last;
  end

  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    top <= TOP_W'(STACK_DEPTH))
    else $error("hull stack pointer beyond depth");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_empty) |-> (out_x == '0 && out_y == '0 && out_last))
    else $error("empty result carries a vertex");
  a_pop_keeps_two: assert property (@(posedge clk) disable iff (rst)
    (cmd.hcmp && status.turn_bad) |-> (top >= TOP_W'(2)))
    else $error("pop with fewer than two stacked vertices");
endmodule

// ===== rtl/chmc_ctrl.sv =====
// Controller state machine sequencing load, sort, hull pass and emission.
`timescale 1ns / 1ps
module chmc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  chmc_pkg::status_t  status,
  output chmc_pkg::cmd_t     cmd
);
  import chmc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = status.full ? S_ENDPT : S_INS_RD;
        end
      end
      S_INS_RD:  state_next = status.j_zero ? S_INS_KEY : S_INS_CMP;
      S_INS_CMP: state_next = status.key_less ? S_INS_RD : S_INS_KEY;
      S_INS_KEY: state_next = S_ENDPT;
      S_ENDPT: begin
        if (!status.last) begin
          state_next = S_IDLE;
        end else begin
          state_next = status.cnt_ge3 ? S_HINIT : S_EMPTY;
        end
      end
      S_HINIT:  state_next = S_HFETCH;
      S_HFETCH: state_next = S_HCAP;
      S_HCAP:   state_next = S_HCHK;
      S_HCHK:   state_next = status.can_test ? S_HRA : S_HPUSH;
      S_HRA:    state_next = S_HRB;
      S_HRB:    state_next = S_HMUL;
      S_HMUL:   state_next = S_HPROD;
      S_HPROD:  state_next = S_HCMP;
      S_HCMP:   state_next = status.turn_bad ? S_HCHK : S_HPUSH;
      S_HPUSH:  state_next = status.upper_end ? S_EINIT : S_HFETCH;
      S_EINIT:  state_next = status.hull_small ? S_EMPTY : S_ERD;
      S_ERD:    state_next = S_ELD;
      S_ELD:    state_next = S_EWAIT;
      S_EMPTY:  state_next = S_EWAIT;
      S_EWAIT: begin
        if (status.out_taken) begin
          state_next = status.out_last ? S_CLR : S_ERD;
        end
      end
      S_CLR:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_INS_RD:  cmd.ins_rd  = 1'b1;
      S_INS_CMP: cmd.ins_cmp = 1'b1;
      S_INS_KEY: cmd.ins_key = 1'b1;
      S_ENDPT: begin
      end
      S_HINIT:  cmd.hinit  = 1'b1;
      S_HFETCH: cmd.hfetch = 1'b1;
      S_HCAP:   cmd.hcap   = 1'b1;
      S_HCHK: begin
      end
      S_HRA:    cmd.hra    = 1'b1;
      S_HRB:    cmd.hrb    = 1'b1;
      S_HMUL:   cmd.hmul   = 1'b1;
      S_HPROD:  cmd.hprod  = 1'b1;
      S_HCMP:   cmd.hcmp   = 1'b1;
      S_HPUSH:  cmd.push   = 1'b1;
      S_EINIT:  cmd.einit  = 1'b1;
      S_ERD:    cmd.erd    = 1'b1;
      S_ELD:    cmd.eld    = 1'b1;
      S_EMPTY:  cmd.eempty = 1'b1;
      S_EWAIT: begin
      end
      S_CLR:    cmd.clear  = 1'b1;
      default: begin
      end
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == S_IDLE))
    else $error("input taken outside idle");
  a_push_after_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.hcap |=> (state == S_HCHK))
    else $error("captured point not tested");
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> $past(status.out_taken && status.out_last))
    else $error("set cleared before final result");
endmodule

// ===== rtl/convex_hull_monotone_chain_core.sv =====
// Top level of the monotone chain convex hull block.
// Load: each point is insertion-sorted into the store by x then y, shifting each stored
//   point it moves past; a point that arrives at a full store is dropped and flagged.
// Hull pass: lower then upper chain, popping the stack while a turn is not left; then the
//   vertices are emitted one by one. One set is processed at a time; input is held off from
//   the final point until the set is cleared after the last result item is taken. Reset empties the set.
`timescale 1ns / 1ps
module convex_hull_monotone_chain_core (
  input  logic  clk,
  input  logic  rst,
  chmc_point_if.sink  point,
  chmc_hull_if.source hull
);
  import chmc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller only sequences; all storage and arithmetic live in the datapath.
  chmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (point.valid),
    .in_ready (point.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath owns the output register, so a result waits there until it is taken.
  chmc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_x        (point.point_x),
    .in_y        (point.point_y),
    .in_last     (point.last_point),
    .out_valid   (hull.valid),
    .out_ready   (hull.ready),
    .out_x       (hull.hull_x),
    .out_y       (hull.hull_y),
    .out_last    (hull.hull_last),
    .out_empty   (hull.hull_empty),
    .out_dropped (hull.points_dropped)
  );
endmodule

// ===== test/chmc_tb_if.sv =====
// Item types shared by the testbench of the convex hull block.
`timescale 1ns / 1ps
package chmc_tb_pkg;
  import chmc_pkg::*;
  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;
  } pt_item_t;
  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;
    logic                         empty;
    logic                         dropped;
  } vertex_t;
endpackage

// ===== test/tb_convex_hull_monotone_chain_core.sv =====
// Self-checking testbench of the monotone chain convex hull block.
`timescale 1ns / 1ps
module tb_convex_hull_monotone_chain_core;
  import chmc_pkg::*;
  import chmc_tb_pkg::*;

  localparam int IDLE_PCT = 31;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  chmc_point_if point ();
  chmc_hull_if hull ();

  convex_hull_monotone_chain_core dut (.clk(clk), .rst(rst), .point(point), .hull(hull));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Items waiting to be offered, and hull vertices the predictor expects.
  pt_item_t  pending_points[$];
  vertex_t   expected_vertices[$];

  // Predictor state: the current set of points as the block stores it.
  longint set_x[$];
  longint set_y[$];
  bit     set_overflow;

  int  errors = 0;
  int  sets_done = 0;
  int  vertices_seen = 0;
  int  points_taken = 0;
  int  sent = 0;
  int  drain_at = 0;
  bit  no_idle = 1'b0;
  bit  in_acc = 1'b0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  pt_item_t drv_item;
  pt_item_t mon_item;
  vertex_t  exp_v;

  task automatic report(input string what);
    errors++;
    $display("ERROR @%0t: %s", $realtime, what);
  endtask

  task automatic finish_run();
    $display("Run covered %0d points in %0d sets and %0d hull items, with tiny, degenerate,",
             points_taken, sets_done, vertices_seen);
    $display("overflowing and full-range sets, a long output stall and a drain pause.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  endtask

  function automatic longint cross_turn(longint ox, longint oy, longint ax, longint ay,
                                        longint bx, longint by);
    return (ax - ox) * (by - oy) - (ay - oy) * (bx - ox);
  endfunction

  // Accepts one point into the predicted set and, on a final point, queues the hull.
  task automatic predict_hull(input pt_item_t p);
    longint sx[$];
    longint sy[$];
    longint hx[$];
    longint hy[$];
    longint tx;
    longint ty;
    int n;
    int j;
    int lower_top;
    bit dropped;
    vertex_t v;
    if (set_x.size() < MAX_POINTS) begin
      set_x.insert(set_x.size(), longint'(p.x));
      set_y.insert(set_y.size(), longint'(p.y));
    end else begin
      set_overflow = 1'b1;
    end
    if (!p.last) return;
    dropped = set_overflow;
    n = set_x.size();
    if (n >= 3) begin
      // Insertion sort by x then y, stable as in the block.
      for (int i = 0; i < n; i++) begin
        tx = set_x[i];
        ty = set_y[i];
        j = sx.size();
        while (j > 0 && (tx < sx[j-1] || (tx == sx[j-1] && ty < sy[j-1]))) j--;
        sx.insert(j, tx);
        sy.insert(j, ty);
      end
      for (int i = 0; i < n; i++) begin
        while (hx.size() >= 2 && cross_turn(hx[$-1], hy[$-1], hx[$], hy[$], sx[i], sy[i]) <= 0)
        begin
          hx.delete(hx.size() - 1);
          hy.delete(hy.size() - 1);
        end
        if (hx.size() < STACK_DEPTH) begin
          hx.insert(hx.size(), sx[i]);
          hy.insert(hy.size(), sy[i]);
        end
      end
      lower_top = hx.size();
      for (int i = n - 2; i >= 0; i--) begin
        while (hx.size() > lower_top && hx.size() >= 2 &&
               cross_turn(hx[$-1], hy[$-1], hx[$], hy[$], sx[i], sy[i]) <= 0) begin
          hx.delete(hx.size() - 1);
          hy.delete(hy.size() - 1);
        end
        if (hx.size() < STACK_DEPTH) begin
          hx.insert(hx.size(), sx[i]);
          hy.insert(hy.size(), sy[i]);
        end
      end
    end
    if (hx.size() < 4) begin
      v.x = '0;
      v.y = '0;
      v.last = 1'b1;
      v.empty = 1'b1;
      v.dropped = dropped;
      expected_vertices.insert(expected_vertices.size(), v);
    end else begin
      for (int k = 0; k < hx.size() - 1; k++) begin
        v.x = hx[k][COORD_BITS-1:0];
        v.y = hy[k][COORD_BITS-1:0];
        v.last = (k == hx.size() - 2);
        v.empty = 1'b0;
        v.dropped = dropped;
        expected_vertices.insert(expected_vertices.size(), v);
      end
    end
    set_x.delete();
    set_y.delete();
    set_overflow = 1'b0;
    sets_done++;
  endtask

  task automatic add_point(input int x, input int y, input bit last);
    pt_item_t p;
    p.x = x[COORD_BITS-1:0];
    p.y = y[COORD_BITS-1:0];
    p.last = last;
    pending_points = {pending_points, p};
  endtask

  // Random set: mostly small coordinate spans so turns matter, some full-range.
  task automatic add_random_set(input int n, input bit wide);
    int x;
    int y;
    for (int i = 0; i < n; i++) begin
      if (wide) begin
        x = $urandom;
        y = $urandom;
      end else begin
        x = $urandom_range(40) - 20;
        y = $urandom_range(40) - 20;
      end
      add_point(x, y, i == n - 1);
    end
  endtask

  // Driver: offers queued points, changing inputs at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      point.valid      <= 1'b0;
      point.point_x    <= '0;
      point.point_y    <= '0;
      point.last_point <= 1'b0;
    end else if (!point.valid || in_acc) begin
      no_idle = (sent >= 20) && (sent < 90);
      if (pending_points.size() == 0 ||
          (sent == drain_at && expected_vertices.size() != 0) ||
          (!no_idle && $urandom_range(99) < IDLE_PCT)) begin
        point.valid <= 1'b0;
      end else begin
        drv_item = pending_points.pop_front();
        point.valid      <= 1'b1;
        point.point_x    <= drv_item.x;
        point.point_y    <= drv_item.y;
        point.last_point <= drv_item.last;
        sent++;
      end
    end
  end

  // Receiver: random idling, one long hold-off while results are pending.
  always @(negedge clk) begin
    if (rst) begin
      hull.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hull.ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && vertices_seen >= 2) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      hull.ready <= 1'b0;
    end else begin
      hull.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: checks each result against the predictor, then feeds accepted points to it.
  always @(posedge clk) begin
    in_acc = !rst && point.valid && point.ready;
    if (!rst) begin
      if (hull.valid && hull.ready) begin
        vertices_seen++;
        if (expected_vertices.size() == 0) begin
          report("hull item with none expected");
        end else begin
          exp_v = expected_vertices.pop_front();
          if (hull.hull_x !== exp_v.x || hull.hull_y !== exp_v.y ||
              hull.hull_last !== exp_v.last || hull.hull_empty !== exp_v.empty ||
              hull.points_dropped !== exp_v.dropped) begin
            report($sformatf("got (%0d,%0d) l%b e%b d%b, expected (%0d,%0d) l%b e%b d%b",
                             hull.hull_x, hull.hull_y, hull.hull_last, hull.hull_empty,
                             hull.points_dropped, exp_v.x, exp_v.y, exp_v.last,
                             exp_v.empty, exp_v.dropped));
          end
        end
      end
      if (in_acc) begin
        mon_item.x = point.point_x;
        mon_item.y = point.point_y;
        mon_item.last = point.last_point;
        points_taken++;
        predict_hull(mon_item);
      end
    end
  end

  // Watchdog: ends the run when nothing is accepted for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((point.valid && point.ready) || (hull.valid && hull.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        report("no item accepted within the cycle limit");
        finish_run();
      end
    end
  end

  initial begin
    add_random_set(8, 1'b0);
    // Square with an interior point, an edge point and a duplicate corner.
    add_point(0, 0, 1'b0);
    add_point(64, 0, 1'b0);
    add_point(32, 0, 1'b0);
    add_point(64, 64, 1'b0);
    add_point(32, 32, 1'b0);
    add_point(0, 64, 1'b0);
    add_point(0, 0, 1'b1);
    // Too few points.
    add_point(5, -7, 1'b0);
    add_point(-3, 9, 1'b1);
    add_point(100, 100, 1'b1);
    // All points on one line.
    add_point(48, 48, 1'b0);
    add_point(0, 0, 1'b0);
    add_point(32, 32, 1'b0);
    add_point(16, 16, 1'b1);
    // Triangle with repeated vertices.
    add_point(0, 0, 1'b0);
    add_point(80, 0, 1'b0);
    add_point(0, 0, 1'b0);
    add_point(0, 80, 1'b0);
    add_point(80, 0, 1'b1);
    // More points than the store holds.
    add_random_set(66, 1'b0);
    drain_at = pending_points.size();
    // Extreme coordinates.
    add_point(32767, 32767, 1'b0);
    add_point(-32768, -32768, 1'b0);
    add_point(32767, -32768, 1'b0);
    add_point(-32768, 32767, 1'b1);
    add_random_set(5, 1'b1);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    forever begin
      @(posedge clk);
      if (pending_points.size() == 0 && !point.valid && expected_vertices.size() == 0 &&
          sets_done > 0) begin
        break;
      end
    end
    repeat (20) @(posedge clk);
    if (expected_vertices.size() != 0) begin
      report("expected hull items never arrived");
    end
    finish_run();
  end

endmodule

// ===== files.f =====
rtl/chmc_pkg.sv
rtl/chmc_if.sv
rtl/chmc_ram.sv
rtl/chmc_dp.sv
rtl/chmc_ctrl.sv
rtl/convex_hull_monotone_chain_core.sv
test/chmc_tb_if.sv
test/tb_convex_hull_monotone_chain_core.sv
